FILE: hdl/top_k_rating_filter_defines.svh
// Assertion macros used by the back part of the top-k rating filter RTL.
`ifndef TOP_K_RATING_FILTER_DEFINES_SVH
`define TOP_K_RATING_FILTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TKRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define TKRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/tkrf_pkg.sv
// Types and constants shared by the top-k rating filter modules.
`default_nettype none

package tkrf_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_KEEP_LIMIT        = 2'd0;
    localparam logic [1:0] CFG_RATING_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_UNCHANGED_PENALTY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [3:0] RST_KEEP_LIMIT        = 4'd5;
    localparam logic       RST_RATING_SOURCE     = 1'b1;
    localparam logic [7:0] RST_UNCHANGED_PENALTY = 8'd10;

    // Rating source codes
    localparam logic SRC_GIVEN    = 1'b0;
    localparam logic SRC_COMPUTED = 1'b1;

    // Start value of the lowest-rating search
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    // Configuration seen by the front and back parts
    typedef struct packed {
        logic [3:0] keep_limit;
        logic       rating_source;
        logic [7:0] unchanged_penalty;
    } t_cfg;

    // One rated request travelling from front to back
    typedef struct packed {
        logic               start_pass;
        logic [15:0]        item_id;
        logic signed [31:0] score;
    } t_req;

    // Queue status flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: hdl/tkrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tkrf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/tkrf_front.sv
// Front part: accepts input requests and forms the rating of each one.
`default_nettype none

module tkrf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tkrf_pkg::t_cfg     i_cfg,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_start_pass,
    input  wire logic [15:0]        i_item_id,
    input  wire logic signed [31:0] i_given_rating,
    input  wire logic [15:0]        i_added_count,
    input  wire logic [15:0]        i_removed_count,
    input  wire logic [15:0]        i_unchanged_count,
    input  wire tkrf_pkg::t_q_stat  i_q_stat,
    output logic                    o_push,
    output tkrf_pkg::t_req          o_req
);
    import tkrf_pkg::*;

    logic               r_valid;
    logic               r_start;
    logic [15:0]        r_id;
    logic signed [31:0] r_given;
    logic               r_src;
    logic [16:0]        r_sum;
    logic [23:0]        r_prod;
    logic               accept;
    logic signed [31:0] computed;

    // Hold the stage while the queue is full
    assign o_stall = r_valid & i_q_stat.full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_q_stat.full;

    // Track stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the request, the count sum and the penalty product
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start <= i_start_pass;
            r_id    <= i_item_id;
            r_given <= i_given_rating;
            r_src   <= i_cfg.rating_source;
            r_sum   <= {1'b0, i_added_count} + {1'b0, i_removed_count};
            r_prod  <= i_cfg.unchanged_penalty * i_unchanged_count;
        end
    end

    // Finish the rating and pick its source
    assign computed = $signed({15'd0, r_sum} - {8'd0, r_prod});

    always_comb begin
        o_req.start_pass = r_start;
        o_req.item_id    = r_id;
        o_req.score      = (r_src == SRC_COMPUTED) ? computed : r_given;
    end

endmodule

`default_nettype wire

FILE: hdl/tkrf_queue.sv
// Two-entry queue that decouples the front part from the back part.
`default_nettype none

module tkrf_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tkrf_pkg::t_req    i_req,
    input  wire logic              i_pop,
    output tkrf_pkg::t_req         o_head,
    output tkrf_pkg::t_q_stat      o_stat
);
    import tkrf_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tkrf_back.sv
// Back part: scans the slot table, then keeps, replaces or drops each request.
`default_nettype none
`include "top_k_rating_filter_defines.svh"

module tkrf_back #(
    parameter int MAX_SLOTS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tkrf_pkg::t_cfg     i_cfg,
    input  wire tkrf_pkg::t_req     i_head,
    input  wire tkrf_pkg::t_q_stat  i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_kept,
    output logic                    o_evicted_valid,
    output logic [15:0]             o_evicted_id,
    output logic signed [31:0]      o_item_score
);
    import tkrf_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FW = $clog2(MAX_SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]         r_state;
    t_req               r_cur;
    logic [FW-1:0]      r_fill;
    logic [AW-1:0]      r_idx;
    logic               r_chk;
    logic [AW-1:0]      r_chk_idx;
    logic signed [31:0] r_low;
    logic [AW-1:0]      r_low_idx;
    logic [15:0]        r_low_id;
    logic               r_have;
    logic               r_out_valid;
    logic               r_out_kept;
    logic               r_out_ev;
    logic [15:0]        r_out_ev_id;
    logic signed [31:0] r_out_score;

    logic [FW-1:0]      eff_fill;
    logic [7:0]         limit;
    logic               out_free;
    logic               append;
    logic               replace;
    logic               commit;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [47:0]        ram_rdata;
    logic [15:0]        rd_id;
    logic signed [31:0] rd_score;

    // Slot table: id in the upper 16 bits, rating in the lower 32
    tkrf_ram #(
        .WIDTH (48),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_cur.item_id, r_cur.score}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[47:32];
    assign rd_score = $signed(ram_rdata[31:0]);

    // Clip the limit to the table depth
    always_comb begin
        if ({4'd0, i_cfg.keep_limit} > 8'(MAX_SLOTS)) begin
            limit = 8'(MAX_SLOTS);
        end else begin
            limit = {4'd0, i_cfg.keep_limit};
        end
    end

    assign o_pop    = (r_state == ST_IDLE) & ~i_q_stat.empty;
    assign eff_fill = i_head.start_pass ? '0 : r_fill;
    assign out_free = ~r_out_valid | ~i_stall;

    // Decide between append, replace and drop
    assign append  = (8'(r_fill) < limit) & (r_cur.score > 32'sd0);
    assign replace = ~append & r_have & (r_cur.score > r_low);
    assign commit  = (r_state == ST_DECIDE) & out_free;
    assign ram_we  = commit & (append | replace);
    assign ram_waddr = append ? AW'(r_fill) : r_low_idx;

    // Sequence one request: load, scan, decide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_chk <= (r_state == ST_SCAN);
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_fill  <= eff_fill;
                        r_state <= (eff_fill == '0) ? ST_DECIDE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (FW'(r_idx) + FW'(1) == r_fill) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (commit) begin
                        if (append) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Load the request and step the read address
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (o_pop) begin
            r_cur <= i_head;
            r_idx <= '0;
        end else if (r_state == ST_SCAN && FW'(r_idx) + FW'(1) != r_fill) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Track the first lowest rating as slot data returns
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_low  <= INT_MAX;
            r_have <= 1'b0;
        end else if (r_chk && rd_score < r_low) begin
            r_low     <= rd_score;
            r_low_idx <= r_chk_idx;
            r_low_id  <= rd_id;
            r_have    <= 1'b1;
        end
    end

    // Hold the result until the output request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (~i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_kept  <= append | replace;
            r_out_ev    <= replace;
            r_out_ev_id <= replace ? r_low_id : 16'd0;
            r_out_score <= r_cur.score;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kept          = r_out_kept;
    assign o_evicted_valid = r_out_ev;
    assign o_evicted_id    = r_out_ev_id;
    assign o_item_score    = r_out_score;

    // Checks on table and result consistency
    `TKRF_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(MAX_SLOTS))
    `TKRF_ASSERT_IMP(a_we_in_decide, i_clk, i_rst_n, ram_we, r_state == ST_DECIDE)
    `TKRF_ASSERT_IMP(a_ev_kept, i_clk, i_rst_n, r_out_valid && r_out_ev, r_out_kept)
    `TKRF_ASSERT_IMP(a_ev_id_zero, i_clk, i_rst_n, r_out_valid && !r_out_ev,
        r_out_ev_id == 16'd0)
    `TKRF_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != ST_IDLE)

endmodule

`default_nettype wire

FILE: hdl/top_k_rating_filter.sv
// Top level of the streaming top-k rating filter.
//
//  channel   direction  handshake          payload
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//  request   in         i_valid / o_stall  start_pass, item_id, ratings, counts
//  result    out        o_valid / i_stall  kept, evicted_valid/id, item_score
//
// A request is registered in the front stage (count sum and penalty product
// captured, rating formed on the way out), then waits in a two-entry queue.
// The back takes one request at a time: it loads it, reads each occupied slot
// through the registered RAM read port in turn, waits for the last read and
// then decides; an empty table (or a new pass) goes from load straight to the
// decide step, which also waits while a held result is still stalled.
// Reset empties the table through its fill count; no clearing pass is run.
// Either side may stall freely: the queue and the result register absorb it.
`default_nettype none

module top_k_rating_filter #(
    parameter int MAX_SLOTS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_start_pass,
    input  wire logic [15:0]        i_item_id,
    input  wire logic signed [31:0] i_given_rating,
    input  wire logic [15:0]        i_added_count,
    input  wire logic [15:0]        i_removed_count,
    input  wire logic [15:0]        i_unchanged_count,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_kept,
    output logic                    o_evicted_valid,
    output logic [15:0]             o_evicted_id,
    output logic signed [31:0]      o_item_score
);
    import tkrf_pkg::*;

    t_cfg    r_cfg;
    t_req    push_req;
    t_req    head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_limit        <= RST_KEEP_LIMIT;
            r_cfg.rating_source     <= RST_RATING_SOURCE;
            r_cfg.unchanged_penalty <= RST_UNCHANGED_PENALTY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEEP_LIMIT:        r_cfg.keep_limit        <= i_cfg_data[3:0];
                CFG_RATING_SOURCE:     r_cfg.rating_source     <= i_cfg_data[0];
                CFG_UNCHANGED_PENALTY: r_cfg.unchanged_penalty <= i_cfg_data;
                default:               r_cfg                   <= r_cfg;
            endcase
        end
    end

    tkrf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_pass      (i_start_pass),
        .i_item_id         (i_item_id),
        .i_given_rating    (i_given_rating),
        .i_added_count     (i_added_count),
        .i_removed_count   (i_removed_count),
        .i_unchanged_count (i_unchanged_count),
        .i_q_stat          (q_stat),
        .o_push            (push),
        .o_req             (push_req)
    );

    tkrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tkrf_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kept          (o_kept),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_item_score    (o_item_score)
    );

endmodule

`default_nettype wire

FILE: dv/topk_result_tracker.sv
// Tracks the top-k rating filter: predicts each result and compares it with the block.
module topk_result_tracker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_stall,
    input  wire logic               i_start_pass,
    input  wire logic [15:0]        i_item_id,
    input  wire logic signed [31:0] i_given_rating,
    input  wire logic [15:0]        i_added_count,
    input  wire logic [15:0]        i_removed_count,
    input  wire logic [15:0]        i_unchanged_count,
    input  wire logic               i_res_valid,
    input  wire logic               i_res_stall,
    input  wire logic               i_kept,
    input  wire logic               i_evicted_valid,
    input  wire logic [15:0]        i_evicted_id,
    input  wire logic signed [31:0] i_item_score,
    output int                      o_fail_count,
    output int                      o_pending
);
    import tkrf_pkg::*;

    localparam int SLOT_COUNT = 8;

    typedef struct packed {
        logic               kept;
        logic               evicted_valid;
        logic [15:0]        evicted_id;
        logic signed [31:0] item_score;
    } t_outcome;

    // Shadow copy of the kept table and the registers
    logic [15:0]        kept_ids [SLOT_COUNT];
    logic signed [31:0] kept_scores [SLOT_COUNT];
    int                 kept_fill;
    logic [3:0]         keep_limit;
    logic               rating_source;
    logic [7:0]         unchanged_penalty;

    t_outcome           expected_outcomes [$];
    int                 mismatches;

    initial begin
        mismatches   = 0;
        kept_fill    = 0;
    end

    // Rate one request and place it in the shadow table
    function automatic t_outcome rate_and_place(input logic sp, input logic [15:0] id,
                                                input logic signed [31:0] given,
                                                input logic [15:0] added,
                                                input logic [15:0] removed,
                                                input logic [15:0] unchanged);
        t_outcome           res;
        longint             score;
        logic signed [31:0] lowest;
        int                 lowest_at;
        int                 cap;
        logic               found;
        res       = '0;
        lowest    = INT_MAX;
        lowest_at = 0;
        found     = 1'b0;
        cap       = (keep_limit > SLOT_COUNT) ? SLOT_COUNT : int'(keep_limit);
        if (sp)
            kept_fill = 0;
        if (rating_source == SRC_COMPUTED)
            score = longint'(added) + longint'(removed)
                  - longint'(unchanged_penalty) * longint'(unchanged);
        else
            score = longint'(given);
        // Find the first lowest occupied slot
        for (int i = 0; i < kept_fill; i++) begin
            if (kept_scores[i] < lowest) begin
                lowest    = kept_scores[i];
                lowest_at = i;
                found     = 1'b1;
            end
        end
        if (kept_fill < cap && score > 0) begin
            kept_ids[kept_fill]    = id;
            kept_scores[kept_fill] = score[31:0];
            kept_fill++;
            res.kept = 1'b1;
        end else if (found && score > longint'(lowest)) begin
            res.evicted_valid      = 1'b1;
            res.evicted_id         = kept_ids[lowest_at];
            kept_ids[lowest_at]    = id;
            kept_scores[lowest_at] = score[31:0];
            res.kept               = 1'b1;
        end
        res.item_score = score[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            kept_fill         = 0;
            keep_limit        = RST_KEEP_LIMIT;
            rating_source     = RST_RATING_SOURCE;
            unchanged_penalty = RST_UNCHANGED_PENALTY;
            expected_outcomes.delete();
        end else begin
            // Apply register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEEP_LIMIT:        keep_limit        = i_cfg_data[3:0];
                    CFG_RATING_SOURCE:     rating_source     = i_cfg_data[0];
                    CFG_UNCHANGED_PENALTY: unchanged_penalty = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare an accepted result with the oldest expectation
            if (i_res_valid && !i_res_stall) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result accepted with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_kept !== want.kept) begin
                        $error("kept: expected %0d, actual %0d", want.kept, i_kept);
                        mismatches++;
                    end
                    if (i_evicted_valid !== want.evicted_valid) begin
                        $error("evicted_valid: expected %0d, actual %0d",
                               want.evicted_valid, i_evicted_valid);
                        mismatches++;
                    end
                    if (i_evicted_id !== want.evicted_id) begin
                        $error("evicted_id: expected %0d, actual %0d",
                               want.evicted_id, i_evicted_id);
                        mismatches++;
                    end
                    if (i_item_score !== want.item_score) begin
                        $error("item_score: expected %0d, actual %0d",
                               want.item_score, i_item_score);
                        mismatches++;
                    end
                end
            end
            // Predict the outcome of an accepted request
            if (i_req_valid && !i_req_stall)
                expected_outcomes.push_back(rate_and_place(i_start_pass, i_item_id,
                    i_given_rating, i_added_count, i_removed_count, i_unchanged_count));
        end
        o_pending    <= expected_outcomes.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: dv/testbench.sv
// Stimulus and verdict for the top-k rating filter, with the result tracker beside it.
module testbench;
    import tkrf_pkg::*;

    localparam logic [1:0]         CFG_UNUSED   = 2'd3;
    localparam logic signed [31:0] RATING_MIN   = 32'sh8000_0000;
    localparam int                 DRAIN_CYCLES = 40;
    localparam int                 PHASE_ITEMS  = 150;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               cfg_we          = 1'b0;
    logic [1:0]         cfg_index       = '0;
    logic [7:0]         cfg_data        = '0;
    logic               req_valid       = 1'b0;
    logic               req_stall;
    logic               start_pass      = 1'b0;
    logic [15:0]        item_id         = '0;
    logic signed [31:0] given_rating    = '0;
    logic [15:0]        added_count     = '0;
    logic [15:0]        removed_count   = '0;
    logic [15:0]        unchanged_count = '0;
    logic               res_valid;
    logic               res_stall       = 1'b0;
    logic               kept;
    logic               evicted_valid;
    logic [15:0]        evicted_id;
    logic signed [31:0] item_score;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct   = 19;
    int                 recv_idle_pct   = 65;

    always #5 clk = ~clk;

    top_k_rating_filter i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_valid           (req_valid),
        .o_stall           (req_stall),
        .i_start_pass      (start_pass),
        .i_item_id         (item_id),
        .i_given_rating    (given_rating),
        .i_added_count     (added_count),
        .i_removed_count   (removed_count),
        .i_unchanged_count (unchanged_count),
        .o_valid           (res_valid),
        .i_stall           (res_stall),
        .o_kept            (kept),
        .o_evicted_valid   (evicted_valid),
        .o_evicted_id      (evicted_id),
        .o_item_score      (item_score)
    );

    topk_result_tracker i_tracker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_req_valid       (req_valid),
        .i_req_stall       (req_stall),
        .i_start_pass      (start_pass),
        .i_item_id         (item_id),
        .i_given_rating    (given_rating),
        .i_added_count     (added_count),
        .i_removed_count   (removed_count),
        .i_unchanged_count (unchanged_count),
        .i_res_valid       (res_valid),
        .i_res_stall       (res_stall),
        .i_kept            (kept),
        .i_evicted_valid   (evicted_valid),
        .i_evicted_id      (evicted_id),
        .i_item_score      (item_score),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Stall the result channel at random
    always @(posedge clk)
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Offer one request, with random idle cycles ahead of it
    task automatic put_req(input logic sp, input logic [15:0] id,
                           input logic signed [31:0] given, input logic [15:0] added,
                           input logic [15:0] removed, input logic [15:0] unchanged);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        start_pass      <= sp;
        item_id         <= id;
        given_rating    <= given;
        added_count     <= added;
        removed_count   <= removed;
        unchanged_count <= unchanged;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Hold off requests until every result is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all registers while the block is idle
    task automatic set_cfg(input logic [3:0] limit, input logic src, input logic [7:0] pen);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEEP_LIMIT;
        cfg_data  <= {4'($urandom), limit};
        @(posedge clk);
        cfg_index <= CFG_RATING_SOURCE;
        cfg_data  <= {7'($urandom), src};
        @(posedge clk);
        cfg_index <= CFG_UNCHANGED_PENALTY;
        cfg_data  <= pen;
        @(posedge clk);
        // Unmapped index: must be dropped by the block
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one random request, mostly with small ratings so that ties and evictions occur
    task automatic send_random(input logic sp);
        logic signed [31:0] given;
        logic [15:0]        added;
        logic [15:0]        removed;
        logic [15:0]        unchanged;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: given = 32'($signed($urandom_range(0, 48)) - 8);
            5, 6:          given = 32'($urandom);
            7:             given = INT_MAX;
            8:             given = RATING_MIN;
            default:       given = 32'($signed($urandom_range(0, 2)) - 1);
        endcase
        if ($urandom_range(0, 9) < 7) begin
            added     = 16'($urandom_range(0, 20));
            removed   = 16'($urandom_range(0, 20));
            unchanged = 16'($urandom_range(0, 3));
        end else begin
            added     = 16'($urandom);
            removed   = 16'($urandom);
            unchanged = 16'($urandom);
        end
        put_req(sp, 16'($urandom), given, added, removed, unchanged);
    endtask

    initial begin
        int   left;
        logic sp;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, computed ratings, fill and evict
        put_req(1'b1, 16'd1, 32'sd0, 16'd0, 16'd0, 16'd0);
        put_req(1'b0, 16'd2, 32'sd0, 16'hFFFF, 16'hFFFF, 16'd0);
        put_req(1'b0, 16'd3, 32'sd0, 16'd0, 16'd0, 16'hFFFF);
        put_req(1'b0, 16'd4, 32'sd0, 16'd1, 16'd0, 16'd0);
        put_req(1'b0, 16'd5, 32'sd0, 16'd0, 16'd2, 16'd0);
        put_req(1'b0, 16'd6, 32'sd0, 16'd3, 16'd0, 16'd0);
        put_req(1'b0, 16'd7, 32'sd0, 16'd4, 16'd0, 16'd0);
        put_req(1'b0, 16'd8, 32'sd0, 16'd10, 16'd0, 16'd0);

        // Directed: given ratings at the extremes
        set_cfg(4'd8, SRC_GIVEN, 8'd255);
        put_req(1'b1, 16'd10, INT_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        put_req(1'b0, 16'd11, INT_MAX, 16'd0, 16'd0, 16'd0);
        put_req(1'b0, 16'd12, RATING_MIN, 16'd0, 16'd0, 16'd0);
        put_req(1'b0, 16'd13, 32'sd0, 16'd0, 16'd0, 16'd0);

        // Directed: limit lowered, every kept rating at the top value
        set_cfg(4'd2, SRC_GIVEN, 8'd255);
        put_req(1'b0, 16'd14, INT_MAX, 16'd0, 16'd0, 16'd0);
        put_req(1'b0, 16'd15, 32'sd5, 16'd0, 16'd0, 16'd0);

        // Directed: zero limit, most negative computed rating
        set_cfg(4'd0, SRC_COMPUTED, 8'd255);
        put_req(1'b1, 16'hFFFF, 32'sd0, 16'd0, 16'd0, 16'hFFFF);
        put_req(1'b0, 16'd16, 32'sd0, 16'd9, 16'd9, 16'd0);

        // Directed: limit above the slot count is clipped
        set_cfg(4'd15, SRC_GIVEN, 8'd0);
        for (int i = 0; i < 9; i++)
            put_req(i == 0, 16'(20 + i), 32'(100 * (i + 1)), 16'd0, 16'd0, 16'd0);

        // Directed: lower the limit on a full table, replace among all slots
        set_cfg(4'd3, SRC_GIVEN, 8'd0);
        put_req(1'b0, 16'd30, 32'sd5000, 16'd0, 16'd0, 16'd0);

        // Random passes under changing settings and idle patterns
        left = 0;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase / 3)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 65;
                end
                1: begin
                    send_idle_pct = 65;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       set_cfg(4'd8, SRC_GIVEN, 8'd0);
                1:       set_cfg(4'd1, SRC_COMPUTED, 8'd255);
                2:       set_cfg(4'd15, SRC_GIVEN, 8'($urandom));
                3:       set_cfg(4'd4, SRC_COMPUTED, 8'd1);
                default: set_cfg(4'($urandom_range(0, 15)), 1'($urandom),
                                 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4)));
            endcase
            // Either keep the pass running across the register change or start afresh
            if ($urandom_range(0, 1) == 1)
                left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (left == 0) begin
                    left = $urandom_range(1, 24);
                    sp   = 1'b1;
                end else begin
                    sp = ($urandom_range(0, 99) < 4);
                end
                left--;
                send_random(sp);
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Bound the run
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tkrf_pkg.sv
hdl/tkrf_ram.sv
hdl/tkrf_front.sv
hdl/tkrf_queue.sv
hdl/tkrf_back.sv
hdl/top_k_rating_filter.sv
dv/topk_result_tracker.sv
dv/testbench.sv
